>>> hdl/assert_macros.svh
// assertion macros shared by the rle encoder rtl
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// same-cycle implication, ignored while reset is high
`define CHK_IMPLY(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
    else $error(msg);

// next-cycle implication, ignored while reset is high
`define CHK_NEXT(label, clk, rst, ante, cons, msg) \
  label: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
    else $error(msg);

`endif

>>> hdl/tgarle_pkg.sv
// shared types, constants and helpers for the tga rle pixel encoder
`timescale 1ns / 1ps

package tgarle_pkg;

  localparam int PIX_W                 = 24;
  localparam int HDR_W                 = 8;
  localparam int CNT_OUT_W             = 3;
  localparam int OUT_LANES             = 4;
  localparam int DEF_MAX_PACKET        = 128;
  localparam int DEF_PIXELS_PER_RESULT = 4;
  localparam int RUN_BASE              = 127;

  typedef logic [PIX_W-1:0] pixel_t;

  // one pending packet: header info plus the pixel that closes it
  typedef struct packed {
    logic              hdr;
    logic [HDR_W-1:0]  header;
    logic              tail;
    pixel_t            tail_pix;
  } pkt_desc_t;

  // controller to datapath commands
  typedef struct packed {
    logic accept;
    logic start_pkt;
    logic load_out;
  } ctl_cmd_t;

  // datapath to controller status
  typedef struct packed {
    logic will_emit;
    logic pkt_pending;
    logic chunk_last;
    logic out_free;
  } dp_status_t;

  // run packet header for a run of rep pixels
  function automatic logic [HDR_W-1:0] run_header(input logic [HDR_W-1:0] rep);
    return rep + HDR_W'(RUN_BASE);
  endfunction

  // raw packet header for n pixels
  function automatic logic [HDR_W-1:0] raw_header(input logic [HDR_W-1:0] n);
    return n - HDR_W'(1);
  endfunction

endpackage

>>> hdl/tgarle_ctrl.sv
// controller state machine sequencing packet emission
`timescale 1ns / 1ps

module tgarle_ctrl (
  input  logic                   clk,
  input  logic                   rst,
  input  logic                   in_valid,
  output logic                   in_stall,
  input  tgarle_pkg::dp_status_t status,
  output tgarle_pkg::ctl_cmd_t   cmd
);
  import tgarle_pkg::*;

  localparam logic [1:0] ST_IDLE = 2'd0;
  localparam logic [1:0] ST_SEL  = 2'd1;
  localparam logic [1:0] ST_READ = 2'd2;
  localparam logic [1:0] ST_LOAD = 2'd3;

  logic [1:0] state;
  logic [1:0] state_next;

  // next state and commands
  always_comb begin
    state_next    = state;
    cmd           = '0;
    in_stall      = (state != ST_IDLE);
    unique case (state)
      ST_IDLE: begin
        if (in_valid) begin
          cmd.accept = 1'b1;
          if (status.will_emit) state_next = ST_SEL;
        end
      end
      ST_SEL: begin
        cmd.start_pkt = 1'b1;
        state_next    = ST_READ;
      end
      ST_READ: begin
        state_next = ST_LOAD;
      end
      ST_LOAD: begin
        if (status.out_free) begin
          cmd.load_out = 1'b1;
          priority if (!status.chunk_last) state_next = ST_READ;
          else if (status.pkt_pending)    state_next = ST_SEL;
          else                            state_next = ST_IDLE;
        end
      end
      default: state_next = ST_IDLE;
    endcase
  end

  // state register
  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

>>> hdl/tgarle_dpath.sv
// datapath: packet state, raw pixel buffer and result register
`timescale 1ns / 1ps

module tgarle_dpath #(
  parameter int MAX_PACKET        = tgarle_pkg::DEF_MAX_PACKET,
  parameter int PIXELS_PER_RESULT = tgarle_pkg::DEF_PIXELS_PER_RESULT
) (
  input  logic                           clk,
  input  logic                           rst,
  input  logic                           cfg_we,
  input  logic                           cfg_data,
  input  logic [7:0]                     red,
  input  logic [7:0]                     green,
  input  logic [7:0]                     blue,
  input  logic                           last_pixel,
  input  logic                           out_stall,
  input  tgarle_pkg::ctl_cmd_t           cmd,
  output tgarle_pkg::dp_status_t         status,
  output logic                           out_valid,
  output logic                           has_header,
  output logic [tgarle_pkg::HDR_W-1:0]   header_byte,
  output logic [tgarle_pkg::CNT_OUT_W-1:0] pixel_count,
  output logic [tgarle_pkg::PIX_W-1:0]   pixel_a,
  output logic [tgarle_pkg::PIX_W-1:0]   pixel_b,
  output logic [tgarle_pkg::PIX_W-1:0]   pixel_c,
  output logic [tgarle_pkg::PIX_W-1:0]   pixel_d,
  output logic                           last_result
);
  import tgarle_pkg::*;

  localparam int PPR    = PIXELS_PER_RESULT;
  localparam int CNT_W  = $clog2(MAX_PACKET + 1);
  localparam int ROWS   = (MAX_PACKET + PPR - 1) / PPR;
  localparam int ROW_W  = (ROWS > 1) ? $clog2(ROWS) : 1;
  localparam int LANE_W = (PPR > 1) ? $clog2(PPR) : 1;

  // packet state; the newest pending raw pixel lives in prev, not the buffer
  logic             compress;
  pixel_t           prev;
  logic [CNT_W-1:0] rep;
  logic [CNT_W-1:0] rawc;
  logic             started;
  logic [ROW_W-1:0] wr_row;
  logic [LANE_W-1:0] wr_lane;

  pixel_t            prev_next;
  logic [CNT_W-1:0]  rep_next;
  logic [CNT_W-1:0]  rawc_next;
  logic              started_next;
  logic              ptr_clear;
  logic              mem_we;

  // pending packets decided at accept
  logic              p1_valid, p2_valid;
  pkt_desc_t         p1, p2;
  logic [CNT_W-1:0]  p1_n, p2_n;
  logic              p1_valid_next, p2_valid_next;
  pkt_desc_t         p1_next, p2_next;
  logic [CNT_W-1:0]  p1_n_next, p2_n_next;

  // packet being drained
  pkt_desc_t         cur;
  logic [CNT_W-1:0]  left;
  logic [ROW_W-1:0]  cur_row;
  logic              first;

  pixel_t            rd_data [OUT_LANES];
  pixel_t            res_pix [OUT_LANES];
  logic [CNT_OUT_W-1:0] take;

  pixel_t            pix;
  logic              same;
  logic              empty;

  assign pix   = {red, green, blue};
  assign same  = (pix == prev);
  assign empty = (rawc == '0);

  // packet decision for the incoming pixel
  always_comb begin
    prev_next     = prev;
    rep_next      = rep;
    rawc_next     = rawc;
    started_next  = started;
    ptr_clear     = 1'b0;
    mem_we        = 1'b0;
    p1_valid_next = 1'b0;
    p1_next       = '0;
    p1_n_next     = '0;
    p2_valid_next = 1'b0;
    p2_next       = '0;
    p2_n_next     = '0;
    if (!compress) begin
      p2_valid_next    = 1'b1;
      p2_next.tail     = 1'b1;
      p2_next.tail_pix = pix;
      p2_n_next        = CNT_W'(1);
    end else begin
      priority if (!started) begin
        prev_next    = pix;
        rep_next     = CNT_W'(1);
        rawc_next    = '0;
        started_next = 1'b1;
        ptr_clear    = 1'b1;
      end else if (same && empty && (rep < CNT_W'(MAX_PACKET))) begin
        rep_next = rep + CNT_W'(1);
      end else if (!same && empty && (rep == CNT_W'(1))) begin
        mem_we    = 1'b1;
        rawc_next = CNT_W'(2);
        prev_next = pix;
      end else if (!same && !empty && (rawc < CNT_W'(MAX_PACKET))) begin
        mem_we    = 1'b1;
        rawc_next = rawc + CNT_W'(1);
        prev_next = pix;
      end else if (!same && !empty) begin
        // full raw stretch goes out, new pixel opens the next one
        p1_valid_next    = 1'b1;
        p1_next.hdr      = 1'b1;
        p1_next.header   = raw_header(HDR_W'(MAX_PACKET));
        p1_next.tail     = 1'b1;
        p1_next.tail_pix = prev;
        p1_n_next        = CNT_W'(MAX_PACKET);
        rawc_next        = CNT_W'(1);
        prev_next        = pix;
        ptr_clear        = 1'b1;
      end else if (same && !empty) begin
        // stretch minus its last pixel, that pixel starts a run of two
        if (rawc > CNT_W'(1)) begin
          p1_valid_next  = 1'b1;
          p1_next.hdr    = 1'b1;
          p1_next.header = raw_header(HDR_W'(rawc - CNT_W'(1)));
          p1_n_next      = rawc - CNT_W'(1);
        end
        rawc_next = '0;
        rep_next  = CNT_W'(2);
        ptr_clear = 1'b1;
      end else begin
        // run ends: full run or a different pixel
        p1_valid_next    = 1'b1;
        p1_next.hdr      = 1'b1;
        p1_next.header   = run_header(HDR_W'(rep));
        p1_next.tail     = 1'b1;
        p1_next.tail_pix = prev;
        p1_n_next        = CNT_W'(1);
        rep_next         = CNT_W'(1);
        prev_next        = pix;
      end
      // end of image flush
      if (last_pixel) begin
        p2_valid_next    = 1'b1;
        p2_next.hdr      = 1'b1;
        p2_next.tail     = 1'b1;
        p2_next.tail_pix = prev_next;
        if (rawc_next != '0) begin
          p2_next.header = raw_header(HDR_W'(rawc_next));
          p2_n_next      = rawc_next;
        end else begin
          p2_next.header = run_header(HDR_W'(rep_next));
          p2_n_next      = CNT_W'(1);
        end
        rawc_next    = '0;
        rep_next     = CNT_W'(1);
        started_next = 1'b0;
        ptr_clear    = 1'b1;
      end
    end
  end

  // configuration register and packet state
  always_ff @(posedge clk) begin
    if (rst) begin
      compress <= 1'b1;
      prev     <= '0;
      rep      <= CNT_W'(1);
      rawc     <= '0;
      started  <= 1'b0;
      wr_row   <= '0;
      wr_lane  <= '0;
    end else begin
      if (cfg_we) compress <= cfg_data;
      if (cmd.accept) begin
        prev    <= prev_next;
        rep     <= rep_next;
        rawc    <= rawc_next;
        started <= started_next;
        priority if (ptr_clear) begin
          wr_row  <= '0;
          wr_lane <= '0;
        end else if (mem_we) begin
          if (wr_lane == LANE_W'(PPR - 1)) begin
            wr_lane <= '0;
            wr_row  <= wr_row + ROW_W'(1);
          end else begin
            wr_lane <= wr_lane + LANE_W'(1);
          end
        end
      end
    end
  end

  // raw buffer, one memory per result lane below PIXELS_PER_RESULT, rows line up with results
  for (genvar k = 0; k < OUT_LANES; k++) begin : g_lane
    if (k < PPR) begin : g_mem
      pixel_t lane_mem [ROWS];
      always_ff @(posedge clk) begin
        if (cmd.accept && mem_we && (wr_lane == LANE_W'(k))) begin
          lane_mem[wr_row] <= prev;
        end
        rd_data[k] <= lane_mem[cur_row];
      end
    end else begin : g_none
      assign rd_data[k] = '0;
    end
  end

  // pending packet slots and drain position
  always_ff @(posedge clk) begin
    if (rst) begin
      p1_valid <= 1'b0;
      p2_valid <= 1'b0;
      first    <= 1'b0;
    end else begin
      priority if (cmd.accept) begin
        p1_valid <= p1_valid_next;
        p2_valid <= p2_valid_next;
      end else if (cmd.start_pkt) begin
        if (p1_valid) p1_valid <= 1'b0;
        else          p2_valid <= 1'b0;
        first <= 1'b1;
      end else if (cmd.load_out) begin
        first <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.accept) begin
      p1   <= p1_next;
      p1_n <= p1_n_next;
      p2   <= p2_next;
      p2_n <= p2_n_next;
    end
    priority if (cmd.start_pkt) begin
      cur     <= p1_valid ? p1 : p2;
      left    <= p1_valid ? p1_n : p2_n;
      cur_row <= '0;
    end else if (cmd.load_out) begin
      left    <= left - CNT_W'(take);
      cur_row <= cur_row + ROW_W'(1);
    end
  end

  // result assembly for the current chunk
  always_comb begin
    status.chunk_last  = (left <= CNT_W'(PPR));
    take               = status.chunk_last ? CNT_OUT_W'(left) : CNT_OUT_W'(PPR);
    for (int k = 0; k < OUT_LANES; k++) begin
      if (CNT_OUT_W'(k) < take) begin
        if (cur.tail && status.chunk_last && (CNT_OUT_W'(k) == take - CNT_OUT_W'(1)))
          res_pix[k] = cur.tail_pix;
        else
          res_pix[k] = rd_data[k];
      end else begin
        res_pix[k] = '0;
      end
    end
    status.will_emit   = p1_valid_next || p2_valid_next;
    status.pkt_pending = p1_valid || p2_valid;
    status.out_free    = !out_valid || !out_stall;
  end

  // result register
  always_ff @(posedge clk) begin
    if (rst) begin
      out_valid <= 1'b0;
    end else if (cmd.load_out) begin
      out_valid <= 1'b1;
    end else if (!out_stall) begin
      out_valid <= 1'b0;
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load_out) begin
      has_header  <= first && cur.hdr;
      header_byte <= (first && cur.hdr) ? cur.header : '0;
      pixel_count <= take;
      pixel_a     <= res_pix[0];
      pixel_b     <= res_pix[1];
      pixel_c     <= res_pix[2];
      pixel_d     <= res_pix[3];
      last_result <= status.chunk_last && !p1_valid && !p2_valid;
    end
  end

endmodule

>>> hdl/tga_rle_pixel_encoder_top.sv
// tga type-10 rle pixel encoder: an item producing no result is taken unstalled
// an item producing results stalls input through a select state per packet,
// then a buffer row read and a result load each; loads wait on output stall
// the buffer memory reads one row of pixels per result through one read port
// reset is synchronous: clears control, counts and the result valid flag
// the raw buffer is not cleared; entries are read only after being written
`timescale 1ns / 1ps
`include "assert_macros.svh"

module tga_rle_pixel_encoder_top #(
  parameter int MAX_PACKET        = tgarle_pkg::DEF_MAX_PACKET,
  parameter int PIXELS_PER_RESULT = tgarle_pkg::DEF_PIXELS_PER_RESULT
) (
  input  logic                             clk,
  input  logic                             rst,
  input  logic                             cfg_valid,
  output logic                             cfg_ready,
  input  logic                             compress_enable,
  input  logic                             in_valid,
  output logic                             in_stall,
  input  logic [7:0]                       red,
  input  logic [7:0]                       green,
  input  logic [7:0]                       blue,
  input  logic                             last_pixel,
  output logic                             out_valid,
  input  logic                             out_stall,
  output logic                             has_header,
  output logic [tgarle_pkg::HDR_W-1:0]     header_byte,
  output logic [tgarle_pkg::CNT_OUT_W-1:0] pixel_count,
  output logic [tgarle_pkg::PIX_W-1:0]     pixel_a,
  output logic [tgarle_pkg::PIX_W-1:0]     pixel_b,
  output logic [tgarle_pkg::PIX_W-1:0]     pixel_c,
  output logic [tgarle_pkg::PIX_W-1:0]     pixel_d,
  output logic                             last_result
);
  import tgarle_pkg::*;

  ctl_cmd_t   cmd;
  dp_status_t status;

  // configuration transaction always taken
  assign cfg_ready = 1'b1;

  // controller
  tgarle_ctrl u_ctrl (
    .clk      (clk),
    .rst      (rst),
    .in_valid (in_valid),
    .in_stall (in_stall),
    .status   (status),
    .cmd      (cmd)
  );

  // datapath
  tgarle_dpath #(
    .MAX_PACKET        (MAX_PACKET),
    .PIXELS_PER_RESULT (PIXELS_PER_RESULT)
  ) u_dpath (
    .clk         (clk),
    .rst         (rst),
    .cfg_we      (cfg_valid && cfg_ready),
    .cfg_data    (compress_enable),
    .red         (red),
    .green       (green),
    .blue        (blue),
    .last_pixel  (last_pixel),
    .out_stall   (out_stall),
    .cmd         (cmd),
    .status      (status),
    .out_valid   (out_valid),
    .has_header  (has_header),
    .header_byte (header_byte),
    .pixel_count (pixel_count),
    .pixel_a     (pixel_a),
    .pixel_b     (pixel_b),
    .pixel_c     (pixel_c),
    .pixel_d     (pixel_d),
    .last_result (last_result)
  );

  // checks
  `CHK_IMPLY(a_count_range, clk, rst, out_valid, (pixel_count != 3'd0) && (pixel_count <= CNT_OUT_W'(PIXELS_PER_RESULT)), "pixel count out of range")
  `CHK_IMPLY(a_run_single, clk, rst, out_valid && has_header && header_byte[7], pixel_count == 3'd1, "run packet with more than one pixel")
  `CHK_IMPLY(a_hdr_zero, clk, rst, out_valid && !has_header, header_byte == '0, "header byte set without header")
  `CHK_NEXT(a_last_flush, clk, rst, in_valid && !in_stall && last_pixel, in_stall, "last pixel did not start a flush")

endmodule
